FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the estimator RTL
// Same-cycle implication and next-cycle checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SKEC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, disabled while reset is high
`define SKEC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: rtl/skec_pkg.sv
// ----------------------------------------------------------------------------
// skec_pkg
// Types and constants for the scalar Kalman estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package skec_pkg;

   localparam int DATA_WIDTH_DEFAULT     = 32;
   localparam int GAIN_FRAC_BITS_DEFAULT = 16;

   // converge threshold register is fixed Q0.16 plus the 1.0 bit
   localparam int THRESH_WIDTH = 17;
   localparam int CSR_INDEX_WIDTH = 2;

   // register reset values
   localparam int INIT_ESTIMATE_RESET = 0;
   localparam int INIT_ERROR_RESET    = 65536;
   localparam int THRESH_RESET        = 33;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INITIAL_ESTIMATE   = 2'd0,
      CSR_INITIAL_ERROR      = 2'd1,
      CSR_CONVERGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SETUP  = 2'd1,
      ST_DIVIDE = 2'd2,
      ST_UPDATE = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;    // input transfer this cycle
      logic setup;      // form innovation, sum, division start
      logic div_step;   // one quotient bit
      logic div_first;  // first quotient bit, brings in error LSB
      logic commit;     // update state unless converged, and load the result register
   } cmd_type;

   typedef struct packed {
      logic converged;
      logic out_free;   // result register empty or draining this cycle
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/skec_ctrl.sv
// ----------------------------------------------------------------------------
// skec_ctrl
// Sequencer: capture, setup, bit-serial divide, update and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module skec_ctrl #(
   parameter int GAIN_FRAC_BITS = skec_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire skec_pkg::status_type status,
   output skec_pkg::cmd_type       cmd
);

   localparam int CntW = $clog2(GAIN_FRAC_BITS + 1);
   localparam logic [CntW-1:0] LastStep = CntW'(GAIN_FRAC_BITS);

   skec_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]     step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skec_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         skec_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = skec_pkg::ST_SETUP;
            end
         end
         skec_pkg::ST_SETUP: begin
            step_in = '0;
            // frozen once converged: no division needed
            if (status.converged) begin
               state_in = skec_pkg::ST_UPDATE;
            end else begin
               state_in = skec_pkg::ST_DIVIDE;
            end
         end
         skec_pkg::ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               state_in = skec_pkg::ST_UPDATE;
            end
         end
         skec_pkg::ST_UPDATE: begin
            if (status.out_free) begin
               state_in = skec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skec_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         skec_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         skec_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         skec_pkg::ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (step_ff == '0);
         end
         skec_pkg::ST_UPDATE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `SKEC_ASSERT_IMPLY(a_step_range, clock, reset, state_ff == skec_pkg::ST_DIVIDE, step_ff <= LastStep)
   `SKEC_ASSERT_NEXT(a_capture_setup, clock, reset, cmd.capture, state_ff == skec_pkg::ST_SETUP)
   `SKEC_ASSERT_IMPLY(a_ready_quiet, clock, reset, req_ready, !(cmd.div_step || cmd.commit || cmd.setup))

endmodule

`default_nettype wire

FILE: rtl/skec_datapath.sv
// ----------------------------------------------------------------------------
// skec_datapath
// Configuration registers, filter state, restoring divider with Horner
// accumulation of both gain products, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module skec_datapath #(
   parameter int DATA_WIDTH     = skec_pkg::DATA_WIDTH_DEFAULT,
   parameter int GAIN_FRAC_BITS = skec_pkg::GAIN_FRAC_BITS_DEFAULT,
   parameter int CSR_DATA_WIDTH = skec_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire skec_pkg::cmd_type                    cmd,
   output skec_pkg::status_type                      status,
   input  wire logic signed [DATA_WIDTH-1:0]         req_measurement,
   input  wire logic        [DATA_WIDTH-1:0]         req_measurement_variance,
   input  wire logic                                 csr_valid,
   input  wire logic [skec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]            csr_wdata,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]              rsp_estimate_out,
   output logic        [GAIN_FRAC_BITS:0]            rsp_gain_out,
   output logic                                      rsp_converged_out
);

   localparam int DW   = DATA_WIDTH;
   localparam int GF   = GAIN_FRAC_BITS;
   localparam int TW   = skec_pkg::THRESH_WIDTH;
   localparam int MW   = DW + GF + 1;   // |innovation| * gain
   localparam int EW   = DW + GF;       // error * gain
   localparam int CmpW = (GF + 1 > TW) ? GF + 1 : TW;
   localparam logic [GF:0] GainOne = {1'b1, {GF{1'b0}}};

   // configuration
   logic [DW-1:0] cfg_est_ff, cfg_est_in;
   logic [DW-1:0] cfg_err_ff, cfg_err_in;
   logic [TW-1:0] cfg_thresh_ff, cfg_thresh_in;

   // filter state
   logic [DW-1:0] est_ff, est_in;
   logic [DW-1:0] err_ff, err_in;
   logic [GF:0]   gain_ff, gain_in;
   logic          conv_ff, conv_in;
   logic          primed_ff, primed_in;

   // per-item working registers
   logic [DW-1:0] meas_ff, meas_in;
   logic [DW-1:0] var_ff, var_in;
   logic          neg_ff, neg_in;
   logic [DW:0]   mag_ff, mag_in;
   logic [DW:0]   sum_ff, sum_in;
   logic          sum_nz_ff, sum_nz_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [GF:0]   quot_ff, quot_in;
   logic [MW-1:0] acc_m_ff, acc_m_in;
   logic [EW-1:0] acc_e_ff, acc_e_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_est_ff, rsp_est_in;
   logic [GF:0]   rsp_gain_ff, rsp_gain_in;
   logic          rsp_conv_ff, rsp_conv_in;

   // combinational helpers
   logic [DW:0]   innov;
   logic [DW+1:0] trial;
   logic [DW+1:0] diff;
   logic          qbit;
   logic [DW+1:0] est_ext;
   logic [DW+1:0] step_ext;
   logic [DW+1:0] est_sum;
   logic [DW-1:0] est_sat;
   logic [EW-1:0] err_full;
   logic          below;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_est_ff    <= DW'(skec_pkg::INIT_ESTIMATE_RESET);
         cfg_err_ff    <= DW'(skec_pkg::INIT_ERROR_RESET);
         cfg_thresh_ff <= TW'(skec_pkg::THRESH_RESET);
         conv_ff       <= 1'b0;
         primed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_est_ff    <= cfg_est_in;
         cfg_err_ff    <= cfg_err_in;
         cfg_thresh_ff <= cfg_thresh_in;
         conv_ff       <= conv_in;
         primed_ff     <= primed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      est_ff      <= est_in;
      err_ff      <= err_in;
      gain_ff     <= gain_in;
      meas_ff     <= meas_in;
      var_ff      <= var_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      sum_ff      <= sum_in;
      sum_nz_ff   <= sum_nz_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      acc_m_ff    <= acc_m_in;
      acc_e_ff    <= acc_e_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_conv_ff <= rsp_conv_in;
   end

   // configuration writes; unknown index is dropped
   always_comb begin
      cfg_est_in    = cfg_est_ff;
      cfg_err_in    = cfg_err_ff;
      cfg_thresh_in = cfg_thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            skec_pkg::CSR_INITIAL_ESTIMATE:   cfg_est_in    = csr_wdata[DW-1:0];
            skec_pkg::CSR_INITIAL_ERROR:      cfg_err_in    = csr_wdata[DW-1:0];
            skec_pkg::CSR_CONVERGE_THRESHOLD: cfg_thresh_in = csr_wdata[TW-1:0];
            default: begin
               cfg_est_in = cfg_est_ff;
            end
         endcase
      end
   end

   // arithmetic
   always_comb begin
      innov = {meas_ff[DW-1], meas_ff} - {est_ff[DW-1], est_ff};

      // one restoring step; the error LSB is the only nonzero dividend bit left
      trial = {rem_ff, (cmd.div_first ? err_ff[0] : 1'b0)};
      diff  = trial - {1'b0, sum_ff};
      qbit  = sum_nz_ff && (trial >= {1'b0, sum_ff});

      est_ext  = {{2{est_ff[DW-1]}}, est_ff};
      step_ext = {1'b0, acc_m_ff[MW-1:GF]};
      est_sum  = neg_ff ? (est_ext - step_ext) : (est_ext + step_ext);
      if (est_sum[DW+1:DW-1] == 3'b000 || est_sum[DW+1:DW-1] == 3'b111) begin
         est_sat = est_sum[DW-1:0];
      end else if (est_sum[DW+1]) begin
         est_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         est_sat = {1'b0, {(DW-1){1'b1}}};
      end

      // E*(1-g) = E*2^GF - E*g, then drop the fraction
      err_full = {err_ff, {GF{1'b0}}} - acc_e_ff;
      below    = CmpW'(quot_ff) < CmpW'(cfg_thresh_ff);
   end

   // state and working register updates
   always_comb begin
      est_in    = est_ff;
      err_in    = err_ff;
      gain_in   = gain_ff;
      conv_in   = conv_ff;
      primed_in = primed_ff;
      meas_in   = meas_ff;
      var_in    = var_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      sum_in    = sum_ff;
      sum_nz_in = sum_nz_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      acc_m_in  = acc_m_ff;
      acc_e_in  = acc_e_ff;

      if (cmd.capture) begin
         meas_in = req_measurement;
         var_in  = req_measurement_variance;
         if (!primed_ff) begin
            est_in    = cfg_est_ff;
            err_in    = cfg_err_ff;
            primed_in = 1'b1;
         end
      end

      if (cmd.setup) begin
         neg_in    = innov[DW];
         mag_in    = innov[DW] ? ((~innov) + {{DW{1'b0}}, 1'b1}) : innov;
         sum_in    = {1'b0, err_ff} + {1'b0, var_ff};
         sum_nz_in = (err_ff != '0) || (var_ff != '0);
         // quotient fits GF+1 bits, so the top of the dividend starts as E/2
         rem_in    = {2'b00, err_ff[DW-1:1]};
         quot_in   = '0;
         acc_m_in  = '0;
         acc_e_in  = '0;
      end

      if (cmd.div_step) begin
         rem_in   = qbit ? diff[DW:0] : trial[DW:0];
         quot_in  = {quot_ff[GF-1:0], qbit};
         // MSB-first products with the gain as it is produced
         acc_m_in = {acc_m_ff[MW-2:0], 1'b0} + (qbit ? {{GF{1'b0}}, mag_ff} : '0);
         acc_e_in = {acc_e_ff[EW-2:0], 1'b0} + (qbit ? {{GF{1'b0}}, err_ff} : '0);
      end

      if (cmd.commit && !conv_ff) begin
         est_in  = est_sat;
         err_in  = err_full[EW-1:GF];
         gain_in = quot_ff;
         conv_in = below;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_est_in   = rsp_est_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_conv_in  = rsp_conv_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (conv_ff) begin
            rsp_est_in  = est_ff;
            rsp_gain_in = gain_ff;
            rsp_conv_in = 1'b1;
         end else begin
            rsp_est_in  = est_sat;
            rsp_gain_in = quot_ff;
            rsp_conv_in = below;
         end
      end
   end

   assign status.converged  = conv_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_estimate_out  = rsp_est_ff;
   assign rsp_gain_out      = rsp_gain_ff;
   assign rsp_converged_out = rsp_conv_ff;

   `SKEC_ASSERT_IMPLY(a_gain_bound, clock, reset, rsp_valid_ff, rsp_gain_ff <= GainOne)
   `SKEC_ASSERT_NEXT(a_err_shrinks, clock, reset, cmd.commit, err_ff <= $past(err_ff))
   `SKEC_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.commit, !rsp_valid_ff || rsp_ready)

endmodule

`default_nettype wire

FILE: rtl/scalar_kalman_estimator_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_estimator_core
// One-dimensional Kalman estimator for a constant quantity, Q16.16 data.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one measurement and its variance per transfer.
//   rsp_*  : one result per item: estimate, gain (Q1.GAIN_FRAC_BITS), converged.
//   csr_*  : register writes, always ready; write only while the block is idle.
//            Index 0 initial estimate, 1 initial error, 2 converge threshold.
// Sequence:
//   An item is taken in the idle state, then passes a setup state, the divide
//   state (one quotient bit per cycle from the restoring divider, with both
//   gain products accumulated alongside), and an update state that loads the
//   result register. A new item is taken only after the block has returned to
//   idle from the update state. Once converged the divide state is skipped.
// Reset:
//   Registers return to 0 / 1.0 / 33, the filter is unprimed and unconverged;
//   the first item after reset loads the initial estimate and error.
// Stall:
//   The result register holds while rsp_ready is low; the next item is taken
//   and processed, and waits in the update cycle until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_estimator_core #(
   parameter int DATA_WIDTH     = skec_pkg::DATA_WIDTH_DEFAULT,
   parameter int GAIN_FRAC_BITS = skec_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]         req_measurement,
   input  wire logic        [DATA_WIDTH-1:0]         req_measurement_variance,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]              rsp_estimate_out,
   output logic        [GAIN_FRAC_BITS:0]            rsp_gain_out,
   output logic                                      rsp_converged_out,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [skec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [((DATA_WIDTH > skec_pkg::THRESH_WIDTH) ?
                       DATA_WIDTH : skec_pkg::THRESH_WIDTH)-1:0] csr_wdata
);

   localparam int CsrW = (DATA_WIDTH > skec_pkg::THRESH_WIDTH) ?
                         DATA_WIDTH : skec_pkg::THRESH_WIDTH;

   skec_pkg::cmd_type    cmd;
   skec_pkg::status_type status;

   assign csr_ready = 1'b1;

   skec_ctrl #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skec_datapath #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .CSR_DATA_WIDTH (CsrW)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_measurement          (req_measurement),
      .req_measurement_variance (req_measurement_variance),
      .csr_valid                (csr_valid),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_estimate_out         (rsp_estimate_out),
      .rsp_gain_out             (rsp_gain_out),
      .rsp_converged_out        (rsp_converged_out)
   );

endmodule

`default_nettype wire
